### hdl/strm_pkg.sv
// ----------------------------------------------------------------------------
// strm_pkg
// Shared types and codes of the sparse-table range-maximum engine.
// ----------------------------------------------------------------------------
package strm_pkg;

  localparam int IDX_W = 10;
  localparam int VAL_W = 32;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    val_t max_value;
    logic empty_range;
    logic out_of_range;
  } result_t;

endpackage

### hdl/strm_if.sv
// ----------------------------------------------------------------------------
// strm_in_if / strm_out_if
// Valid/ready channels carrying command and result transactions.
// ----------------------------------------------------------------------------
interface strm_in_if;
  import strm_pkg::*;

  logic valid;
  logic ready;
  logic command;
  val_t value;
  logic last;
  idx_t left;
  idx_t right;

  modport source (output valid, command, value, last, left, right, input ready);
  modport sink   (input valid, command, value, last, left, right, output ready);
endinterface

interface strm_out_if;
  import strm_pkg::*;

  logic valid;
  logic ready;
  val_t max_value;
  logic empty_range;
  logic out_of_range;

  modport source (output valid, max_value, empty_range, out_of_range, input ready);
  modport sink   (input valid, max_value, empty_range, out_of_range, output ready);
endinterface

### hdl/strm_engine.sv
// ----------------------------------------------------------------------------
// strm_engine
// Level table memory, sequencer and the shared max unit used for the table
// build and for queries.
// ----------------------------------------------------------------------------
module strm_engine #(
  parameter int DEPTH       = 1024,
  parameter int LEVELS      = 11,
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              cmd,
  input  strm_pkg::val_t    value,
  input  logic              last,
  input  strm_pkg::idx_t    left,
  input  strm_pkg::idx_t    right,
  input  logic              res_ready,
  output logic              idle,
  output logic              res_valid,
  output strm_pkg::result_t res
);
  import strm_pkg::*;

  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int LW    = $clog2(LEVELS + 1);
  localparam int LA    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int AW    = LA + IW;
  localparam int MEM_D = LEVELS << IW;
  localparam int SW    = ((CW > LEVELS) ? CW : LEVELS) + 1;
  localparam int QW    = IDX_W + 1;
  localparam int KW    = $clog2(QW);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BRD  = 3'd1;
  localparam logic [2:0] ST_BWR  = 3'd2;
  localparam logic [2:0] ST_QRD  = 3'd3;
  localparam logic [2:0] ST_QCMP = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          built_r, built_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  idx_t          left_r, left_nxt;
  idx_t          right_r, right_nxt;
  logic          empty_r, empty_nxt;
  logic          oor_r, oor_nxt;
  logic          hit_r, hit_nxt;

  logic signed [VALUE_WIDTH-1:0] lvl_mem_r [MEM_D];
  logic signed [VALUE_WIDTH-1:0] rd_a_r, rd_b_r;
  logic signed [VALUE_WIDTH-1:0] max_val;

  logic                          mem_we, mem_re;
  logic [AW-1:0]                 mem_waddr, raddr_a, raddr_b;
  logic signed [VALUE_WIDTH-1:0] mem_wdata;

  logic [CW-1:0] load_cnt;
  logic [SW-1:0] blk_end;
  logic [IW-1:0] half_idx;
  logic [LW-1:0] lvl_dec;
  logic [QW-1:0] len_q, hi_q;
  logic [KW-1:0] k_raw;
  logic [LA-1:0] k_addr;
  logic          q_empty, q_oor;

  function automatic logic [KW-1:0] floor_log2(input logic [QW-1:0] x);
    logic [KW-1:0] r;
    r = '0;
    for (int b = 0; b < QW; b++) begin
      if (x[b]) r = KW'(b);
    end
    return r;
  endfunction

  assign max_val = (rd_a_r > rd_b_r) ? rd_a_r : rd_b_r;

  always_ff @(posedge clk) begin
    if (mem_we) lvl_mem_r[mem_waddr] <= mem_wdata;
    if (mem_re) begin
      rd_a_r <= lvl_mem_r[raddr_a];
      rd_b_r <= lvl_mem_r[raddr_b];
    end
  end

  always_comb begin
    int k_int;
    load_cnt = built_r ? '0 : count_r;
    blk_end  = SW'(idx_r) + (SW'(1) << lvl_r);
    lvl_dec  = lvl_r - LW'(1);
    half_idx = idx_r + (IW'(1) << lvl_dec);
    len_q    = QW'(right_r) - QW'(left_r) + QW'(1);
    k_raw    = floor_log2(len_q);
    k_int    = int'(k_raw);
    if (k_int > LEVELS - 1) k_int = LEVELS - 1;
    k_addr   = LA'(k_int);
    hi_q     = QW'(right_r) + QW'(1) - (QW'(1) << k_int);
    q_empty  = right_r < left_r;
    q_oor    = !built_r || (32'(right_r) >= 32'(count_r));

    state_nxt = state_r;
    count_nxt = count_r;
    built_nxt = built_r;
    lvl_nxt   = lvl_r;
    idx_nxt   = idx_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    empty_nxt = empty_r;
    oor_nxt   = oor_r;
    hit_nxt   = hit_r;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = max_val;
    mem_re    = 1'b0;
    raddr_a   = '0;
    raddr_b   = '0;
    res_valid = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (cmd == CMD_LOAD) begin
            built_nxt = 1'b0;
            count_nxt = load_cnt;
            if (load_cnt < CW'(DEPTH)) begin
              mem_we    = 1'b1;
              mem_waddr = {LA'(0), load_cnt[IW-1:0]};
              mem_wdata = VALUE_WIDTH'(value);
              count_nxt = load_cnt + CW'(1);
            end
            if (last) begin
              state_nxt = ST_BRD;
              lvl_nxt   = LW'(1);
              idx_nxt   = '0;
            end
          end else begin
            left_nxt  = left;
            right_nxt = right;
            state_nxt = ST_QRD;
          end
        end
      end
      ST_BRD: begin
        if (lvl_r >= LW'(LEVELS)) begin
          built_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else if (blk_end <= SW'(count_r)) begin
          mem_re    = 1'b1;
          raddr_a   = {LA'(lvl_dec), idx_r};
          raddr_b   = {LA'(lvl_dec), half_idx};
          state_nxt = ST_BWR;
        end else begin
          lvl_nxt = lvl_r + LW'(1);
          idx_nxt = '0;
        end
      end
      ST_BWR: begin
        mem_we    = 1'b1;
        mem_waddr = {LA'(lvl_r), idx_r};
        mem_wdata = max_val;
        idx_nxt   = idx_r + IW'(1);
        state_nxt = ST_BRD;
      end
      ST_QRD: begin
        empty_nxt = q_empty;
        oor_nxt   = q_oor;
        hit_nxt   = !q_empty && !q_oor;
        mem_re    = !q_empty && !q_oor;
        raddr_a   = {k_addr, IW'(left_r)};
        raddr_b   = {k_addr, IW'(hi_q)};
        state_nxt = ST_QCMP;
      end
      ST_QCMP: begin
        if (res_ready) begin
          res_valid = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      built_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      built_r <= built_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r   <= lvl_nxt;
    idx_r   <= idx_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
    empty_r <= empty_nxt;
    oor_r   <= oor_nxt;
    hit_r   <= hit_nxt;
  end

  assign idle             = (state_r == ST_IDLE);
  assign res.max_value    = hit_r ? VAL_W'(max_val) : '0;
  assign res.empty_range  = empty_r;
  assign res.out_of_range = oor_r;

endmodule

### hdl/sparse_table_range_max_top.sv
// Load transaction: written on acceptance; next accepted in the following cycle unless last.
// Query transaction: read, compare, result registered; next accepted only once idle again.
// Build after the last load: each entry read then written, a level step each level, a final step.
// Steps set by the single shared max unit and the 2-read/1-write table memory.
// Reset clears the element count, built flag, sequencer and output valid; table contents stay.
// ----------------------------------------------------------------------------
// sparse_table_range_max_top
// Sparse-table range-maximum engine with a registered result channel.
// ----------------------------------------------------------------------------
module sparse_table_range_max_top #(
  parameter int DEPTH       = 1024,
  parameter int LEVELS      = 11,
  parameter int VALUE_WIDTH = 32
) (
  input logic        clk,
  input logic        rst_n,
  strm_in_if.sink    in_chan,
  strm_out_if.source out_chan
);
  import strm_pkg::*;

  logic    eng_idle;
  logic    res_valid;
  logic    res_ready;
  result_t res;

  logic    out_valid_r, out_valid_nxt;
  result_t out_data_r;

  strm_engine #(
    .DEPTH       (DEPTH),
    .LEVELS      (LEVELS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_chan.valid && eng_idle),
    .cmd       (in_chan.command),
    .value     (in_chan.value),
    .last      (in_chan.last),
    .left      (in_chan.left),
    .right     (in_chan.right),
    .res_ready (res_ready),
    .idle      (eng_idle),
    .res_valid (res_valid),
    .res       (res)
  );

  assign res_ready     = !out_valid_r || out_chan.ready;
  assign out_valid_nxt = res_valid || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_data_r <= res;
  end

  assign in_chan.ready         = eng_idle;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.max_value    = out_data_r.max_value;
  assign out_chan.empty_range  = out_data_r.empty_range;
  assign out_chan.out_of_range = out_data_r.out_of_range;

endmodule

### hdl/strm_check.sv
// ----------------------------------------------------------------------------
// strm_check
// Port-level checks of the range-maximum engine, bound to the top level.
// ----------------------------------------------------------------------------
module strm_check (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           in_command,
  input logic           in_last,
  input logic           out_valid,
  input logic           out_ready,
  input strm_pkg::val_t out_max_value,
  input logic           out_empty_range,
  input logic           out_out_of_range
);
  import strm_pkg::*;

  a_reset_no_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_empty_range || out_out_of_range)) |-> (out_max_value == '0))
    else $error("flagged result carries a nonzero maximum");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_command == CMD_QUERY) |=> !in_ready)
    else $error("input ready during query lookup");

  a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_command == CMD_LOAD && in_last) |=> !in_ready)
    else $error("input ready during table build");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_max_value)))
    else $error("stalled result dropped or changed");

endmodule

bind sparse_table_range_max_top strm_check u_strm_check (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .in_command       (in_chan.command),
  .in_last          (in_chan.last),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_max_value    (out_chan.max_value),
  .out_empty_range  (out_chan.empty_range),
  .out_out_of_range (out_chan.out_of_range)
);
